>>> rtl/owbm_pkg.sv
`default_nettype none
// Shared types and constants of the one-wire bus master.
package owbm_pkg;

    localparam int NREG     = 8;
    localparam int IDX_W    = 3;
    localparam int TDATA_W  = 16;
    localparam int ITEM_W   = 12;

    // Timing register indexes
    localparam logic [IDX_W-1:0] R_RST_LOW  = 3'd0;
    localparam logic [IDX_W-1:0] R_PRES_WT  = 3'd1;
    localparam logic [IDX_W-1:0] R_PRES_REC = 3'd2;
    localparam logic [IDX_W-1:0] R_SHORT    = 3'd3;
    localparam logic [IDX_W-1:0] R_LONG     = 3'd4;
    localparam logic [IDX_W-1:0] R_RD_DLY   = 3'd5;
    localparam logic [IDX_W-1:0] R_RD_REC   = 3'd6;
    localparam logic [IDX_W-1:0] R_POLL     = 3'd7;

    // Reset values of the timing registers, in ticks
    localparam int RST_LOW_DEF  = 500;
    localparam int PRES_WT_DEF  = 60;
    localparam int PRES_REC_DEF = 400;
    localparam int SHORT_DEF    = 1;
    localparam int LONG_DEF     = 60;
    localparam int RD_DLY_DEF   = 10;
    localparam int RD_REC_DEF   = 50;
    localparam int POLL_DEF     = 20;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_POLL  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_WAIT  = 4'd2,
        PH_RST_REC   = 4'd3,
        PH_WR_LOW    = 4'd4,
        PH_WR_HIGH   = 4'd5,
        PH_RD_LOW    = 4'd6,
        PH_RD_WAIT   = 4'd7,
        PH_RD_REC    = 4'd8,
        PH_POLL_WAIT = 4'd9,
        PH_POLL      = 4'd10
    } phase_t;

    // Sequencer state apart from the phase timer
    typedef struct packed {
        phase_t      phase;
        logic [2:0]  bit_index;
        logic [7:0]  shift_byte;
        logic        presence_flag;
        logic [7:0]  read_latch;
    } ctl_t;

    // Per-tick bus status
    typedef struct packed {
        logic pull_low;
        logic busy;
        logic done;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/owbm_cfg.sv
`default_nettype none
// Timing register file of the one-wire bus master.
module owbm_cfg
    import owbm_pkg::*;
#(
    parameter int TIME_WIDTH = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [TIME_WIDTH-1:0] cfg_data,
    output logic [TIME_WIDTH-1:0]      cfg_val [NREG]
);

    logic [TIME_WIDTH-1:0] cfg_reg [NREG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[R_RST_LOW]  <= TIME_WIDTH'(RST_LOW_DEF);
            cfg_reg[R_PRES_WT]  <= TIME_WIDTH'(PRES_WT_DEF);
            cfg_reg[R_PRES_REC] <= TIME_WIDTH'(PRES_REC_DEF);
            cfg_reg[R_SHORT]    <= TIME_WIDTH'(SHORT_DEF);
            cfg_reg[R_LONG]     <= TIME_WIDTH'(LONG_DEF);
            cfg_reg[R_RD_DLY]   <= TIME_WIDTH'(RD_DLY_DEF);
            cfg_reg[R_RD_REC]   <= TIME_WIDTH'(RD_REC_DEF);
            cfg_reg[R_POLL]     <= TIME_WIDTH'(POLL_DEF);
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign cfg_val = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/owbm_step.sv
`default_nettype none
// One-tick next-state and status logic of the bus sequencer.
module owbm_step
    import owbm_pkg::*;
#(
    parameter int TIME_WIDTH = 12
) (
    input  wire ctl_t                  ctl,
    input  wire logic [TIME_WIDTH-1:0] time_left,
    input  wire logic [TIME_WIDTH-1:0] cfg_val [NREG],
    input  wire logic                  cmd_valid,
    input  wire logic [1:0]            operation,
    input  wire logic [7:0]            cmd_byte,
    input  wire logic                  line_in,
    output ctl_t                       ctl_next,
    output logic [TIME_WIDTH-1:0]      time_next,
    output stat_t                      stat
);

    logic [7:0] shifted;

    always_comb
    begin
        ctl_next  = ctl;
        time_next = time_left;
        stat      = '0;
        shifted   = {1'b0, ctl.shift_byte[7:1]};

        // Start a command only from idle
        if (ctl.phase == PH_IDLE && cmd_valid)
        begin
            ctl_next.bit_index = 3'd0;
            unique case (op_t'(operation))
                OP_RESET:
                begin
                    ctl_next.phase = PH_RST_LOW;
                    time_next      = cfg_val[R_RST_LOW];
                end
                OP_WRITE:
                begin
                    ctl_next.shift_byte = cmd_byte;
                    ctl_next.phase      = PH_WR_LOW;
                    time_next = cmd_byte[0] ? cfg_val[R_SHORT] : cfg_val[R_LONG];
                end
                OP_READ:
                begin
                    ctl_next.shift_byte = 8'd0;
                    ctl_next.phase      = PH_RD_LOW;
                    time_next           = cfg_val[R_SHORT];
                end
                default:
                begin
                    ctl_next.phase = PH_POLL_WAIT;
                    time_next      = cfg_val[R_POLL];
                end
            endcase
            shifted = {1'b0, ctl_next.shift_byte[7:1]};
        end

        if (ctl_next.phase != PH_IDLE)
        begin
            stat.busy     = 1'b1;
            stat.pull_low = (ctl_next.phase == PH_RST_LOW) || (ctl_next.phase == PH_WR_LOW)
                            || (ctl_next.phase == PH_RD_LOW);
            if (ctl_next.phase == PH_POLL)
            begin
                stat.done = line_in;
            end
            else if (time_next > TIME_WIDTH'(1))
            begin
                time_next = time_next - TIME_WIDTH'(1);
            end
            else
            begin
                // Last tick of a timed phase
                unique case (ctl_next.phase)
                    PH_RST_LOW:
                    begin
                        ctl_next.phase = PH_RST_WAIT;
                        time_next      = cfg_val[R_PRES_WT];
                    end
                    PH_RST_WAIT:
                    begin
                        ctl_next.presence_flag = ~line_in;
                        ctl_next.phase         = PH_RST_REC;
                        time_next              = cfg_val[R_PRES_REC];
                    end
                    PH_WR_LOW:
                    begin
                        ctl_next.phase = PH_WR_HIGH;
                        time_next = ctl_next.shift_byte[0] ? cfg_val[R_LONG]
                                                           : cfg_val[R_SHORT];
                    end
                    PH_WR_HIGH:
                    begin
                        ctl_next.shift_byte = shifted;
                        if (ctl_next.bit_index == 3'd7)
                        begin
                            stat.done = 1'b1;
                        end
                        else
                        begin
                            ctl_next.bit_index = ctl_next.bit_index + 3'd1;
                            ctl_next.phase     = PH_WR_LOW;
                            time_next = shifted[0] ? cfg_val[R_SHORT] : cfg_val[R_LONG];
                        end
                    end
                    PH_RD_LOW:
                    begin
                        ctl_next.phase = PH_RD_WAIT;
                        time_next      = cfg_val[R_RD_DLY];
                    end
                    PH_RD_WAIT:
                    begin
                        ctl_next.shift_byte = {line_in, ctl_next.shift_byte[7:1]};
                        ctl_next.phase      = PH_RD_REC;
                        time_next           = cfg_val[R_RD_REC];
                    end
                    PH_RD_REC:
                    begin
                        if (ctl_next.bit_index == 3'd7)
                        begin
                            ctl_next.read_latch = ctl_next.shift_byte;
                            stat.done           = 1'b1;
                        end
                        else
                        begin
                            ctl_next.bit_index = ctl_next.bit_index + 3'd1;
                            ctl_next.phase     = PH_RD_LOW;
                            time_next          = cfg_val[R_SHORT];
                        end
                    end
                    PH_POLL_WAIT:
                    begin
                        if (line_in)
                        begin
                            stat.done = 1'b1;
                        end
                        else
                        begin
                            ctl_next.phase = PH_POLL;
                            time_next      = '0;
                        end
                    end
                    default:
                    begin
                        stat.done = 1'b1;
                    end
                endcase
            end
            if (stat.done)
            begin
                ctl_next.phase = PH_IDLE;
                time_next      = '0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/onewire_bus_master_unit.sv
`default_nettype none
// Top level of the one-wire bus master: stream channels, tick registers, checks.
//
// Each input transaction is one microsecond tick. s_tdata carries the command
// request (cmd_valid, operation, cmd_byte) together with the bus level sampled
// this tick (line_in). For every input transaction exactly one output
// transaction follows on m_tdata: the open-drain pull-low drive for the bus,
// busy, a one-tick done, the last byte read and the last presence result.
// Timing of a command counts input transactions, not clock cycles.
//
// Path: an accepted tick sits in the input register, is worked in one pass of
// the sequencer logic, and its result is registered in the result register
// that drives m_tdata and m_tvalid. Throughput is one tick per cycle while
// m_tready does not hold a result; the sequencer step is a single
// decrement-compare of the phase timer plus next-phase selection, all between
// the input and result registers.
//
// Stall: while m_tready is low a pending result holds and the input register
// holds one more tick; s_tready drops only when both are full.
// Reset (rst_n, asynchronous, active low): empty both registers, return the
// sequencer to idle, clear read byte and presence, load the timing registers
// with their defaults. cfg_we writes register cfg_index at once; write it only
// while no command is running.
module onewire_bus_master_unit
    import owbm_pkg::*;
#(
    parameter int TIME_WIDTH = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [0] cmd_valid, [2:1] operation, [10:3] cmd_byte, [11] line_in
    input  wire logic [TDATA_W-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] pull_low, [1] busy_res, [2] done_res, [10:3] read_value, [11] presence_seen
    output logic [TDATA_W-1:0]         m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [TIME_WIDTH-1:0] cfg_data
);

    logic                  in_valid_reg;
    logic [ITEM_W-1:0]     in_data_reg;
    logic                  out_valid_reg;
    logic [TDATA_W-1:0]    out_data_reg;
    ctl_t                  ctl_reg;
    ctl_t                  ctl_next;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] time_next;
    logic [TIME_WIDTH-1:0] cfg_val [NREG];
    stat_t                 stat;
    logic                  step;

    // Advance the sequencer when a tick is held and the result slot frees up
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    owbm_cfg #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_val   (cfg_val)
    );

    owbm_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .ctl       (ctl_reg),
        .time_left (time_reg),
        .cfg_val   (cfg_val),
        .cmd_valid (in_data_reg[0]),
        .operation (in_data_reg[2:1]),
        .cmd_byte  (in_data_reg[10:3]),
        .line_in   (in_data_reg[11]),
        .ctl_next  (ctl_next),
        .time_next (time_next),
        .stat      (stat)
    );

    // Control: register occupancy and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_reg       <= '{phase: PH_IDLE, default: '0};
            time_reg      <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
                ctl_reg       <= ctl_next;
                time_reg      <= time_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the tick and the result
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[ITEM_W-1:0];
        end
        if (step)
        begin
            out_data_reg <= {{(TDATA_W - ITEM_W){1'b0}}, ctl_next.presence_flag,
                             ctl_next.read_latch, stat.done, stat.busy, stat.pull_low};
        end
    end

    // A finished command was always busy on its last tick
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && stat.done |-> stat.busy)
        else $error("done without busy");

    // The pull-low drive only comes from a running command
    a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && stat.pull_low |-> stat.busy)
        else $error("bus driven low while idle");

    // Idle sequencer keeps its phase timer cleared
    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.phase == PH_IDLE |-> time_reg == '0)
        else $error("timer left running in idle");

    // An empty result slot never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with free result slot");

endmodule
`default_nettype wire

>>> sim/onewire_bus_master_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking stream testbench of the one-wire bus master top level.
module onewire_bus_master_unit_tb;
    import owbm_pkg::*;

    localparam int TW        = 12;
    localparam int LONG_HOLD = 400;

    // One tick as it travels on s_tdata, lowest field last
    typedef struct packed {
        logic       line;
        logic [7:0] cmd_byte;
        op_t        op;
        logic       cmd_valid;
    } tick_t;

    // One tick status as it travels on m_tdata, lowest field last
    typedef struct packed {
        logic       presence;
        logic [7:0] read_value;
        logic       done;
        logic       busy;
        logic       pull;
    } bus_res_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [TW-1:0]       cfg_data  = '0;

    onewire_bus_master_unit #(.TIME_WIDTH(TW)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Stimulus and expectation stores
    tick_t    tick_q[$];
    bus_res_t bus_expect_q[$];
    tick_t    cur_tick;
    int       ticks_queued    = 0;
    int       results_checked = 0;
    int       errors          = 0;
    int       send_idle_pct   = 0;
    int       stall_pct       = 0;

    // Long receiver hold-off: bump hold_req to start one
    int       hold_req  = 0;
    int       hold_seen = 0;
    int       hold_cnt  = 0;

    // Shadow copy of the bus sequencer
    logic [TW-1:0] timing [NREG];
    phase_t        bus_phase;
    logic [TW-1:0] slot_ticks;
    logic [2:0]    bit_pos;
    logic [7:0]    shift_reg;
    logic          presence_q;
    logic [7:0]    latch_q;

    function automatic void load_phase(phase_t p, logic [TW-1:0] d);
        bus_phase  = p;
        slot_ticks = d;
    endfunction

    function automatic void clear_sequencer();
        timing[R_RST_LOW]  = TW'(RST_LOW_DEF);
        timing[R_PRES_WT]  = TW'(PRES_WT_DEF);
        timing[R_PRES_REC] = TW'(PRES_REC_DEF);
        timing[R_SHORT]    = TW'(SHORT_DEF);
        timing[R_LONG]     = TW'(LONG_DEF);
        timing[R_RD_DLY]   = TW'(RD_DLY_DEF);
        timing[R_RD_REC]   = TW'(RD_REC_DEF);
        timing[R_POLL]     = TW'(POLL_DEF);
        bus_phase  = PH_IDLE;
        slot_ticks = '0;
        bit_pos    = '0;
        shift_reg  = '0;
        presence_q = 1'b0;
        latch_q    = '0;
    endfunction

    // Advance the shadow sequencer by one tick and return the status it shows
    task automatic step_bus(input tick_t t, output bus_res_t r);
        logic done;
        r    = '0;
        done = 1'b0;
        if (bus_phase == PH_IDLE && t.cmd_valid) begin
            bit_pos = '0;
            case (t.op)
                OP_RESET: load_phase(PH_RST_LOW, timing[R_RST_LOW]);
                OP_WRITE:
                begin
                    shift_reg = t.cmd_byte;
                    load_phase(PH_WR_LOW, shift_reg[0] ? timing[R_SHORT] : timing[R_LONG]);
                end
                OP_READ:
                begin
                    shift_reg = '0;
                    load_phase(PH_RD_LOW, timing[R_SHORT]);
                end
                default: load_phase(PH_POLL_WAIT, timing[R_POLL]);
            endcase
        end
        if (bus_phase != PH_IDLE) begin
            r.busy = 1'b1;
            r.pull = (bus_phase == PH_RST_LOW) || (bus_phase == PH_WR_LOW) ||
                     (bus_phase == PH_RD_LOW);
            if (bus_phase == PH_POLL) begin
                done = t.line;
            end else if (slot_ticks > TW'(1)) begin
                slot_ticks = slot_ticks - TW'(1);
            end else begin
                // Last tick of a timed phase: sample where due, pick the next phase
                case (bus_phase)
                    PH_RST_LOW: load_phase(PH_RST_WAIT, timing[R_PRES_WT]);
                    PH_RST_WAIT:
                    begin
                        presence_q = !t.line;
                        load_phase(PH_RST_REC, timing[R_PRES_REC]);
                    end
                    PH_RST_REC: done = 1'b1;
                    PH_WR_LOW:
                        load_phase(PH_WR_HIGH, shift_reg[0] ? timing[R_LONG] : timing[R_SHORT]);
                    PH_WR_HIGH:
                    begin
                        shift_reg = shift_reg >> 1;
                        if (bit_pos == 3'd7) begin
                            done = 1'b1;
                        end else begin
                            bit_pos = bit_pos + 3'd1;
                            load_phase(PH_WR_LOW,
                                       shift_reg[0] ? timing[R_SHORT] : timing[R_LONG]);
                        end
                    end
                    PH_RD_LOW: load_phase(PH_RD_WAIT, timing[R_RD_DLY]);
                    PH_RD_WAIT:
                    begin
                        shift_reg = {t.line, shift_reg[7:1]};
                        load_phase(PH_RD_REC, timing[R_RD_REC]);
                    end
                    PH_RD_REC:
                    begin
                        if (bit_pos == 3'd7) begin
                            latch_q = shift_reg;
                            done    = 1'b1;
                        end else begin
                            bit_pos = bit_pos + 3'd1;
                            load_phase(PH_RD_LOW, timing[R_SHORT]);
                        end
                    end
                    PH_POLL_WAIT:
                    begin
                        if (t.line)
                            done = 1'b1;
                        else
                            load_phase(PH_POLL, '0);
                    end
                    default: done = 1'b1;
                endcase
            end
            if (done) begin
                bus_phase  = PH_IDLE;
                slot_ticks = '0;
            end
        end
        r.done       = done;
        r.read_value = latch_q;
        r.presence   = presence_q;
    endtask

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // Driver: on each accepted transaction, predict its status; then offer the
    // next pending tick unless the sender idles this cycle. Hold the current
    // tick while s_tready is low.
    always @(posedge clk or negedge rst_n) begin
        bus_res_t want;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_bus(cur_tick, want);
                bus_expect_q.push_back(want);
            end
            if (!s_tvalid || s_tready) begin
                if (tick_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_tick  = tick_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= TDATA_W'(cur_tick);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted status against the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        bus_res_t got;
        bus_res_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = bus_res_t'(m_tdata[ITEM_W-1:0]);
                results_checked++;
                if (bus_expect_q.size() == 0) begin
                    flag_error($sformatf("status with nothing expected: %03h", got));
                end else begin
                    want = bus_expect_q.pop_front();
                    if (got.pull !== want.pull || got.busy !== want.busy ||
                        got.done !== want.done || got.read_value !== want.read_value ||
                        got.presence !== want.presence)
                        flag_error($sformatf(
                            {"mismatch pull/busy/done/read/pres: exp %0b %0b %0b %02h %0b",
                             " got %0b %0b %0b %02h %0b"},
                            want.pull, want.busy, want.done, want.read_value, want.presence,
                            got.pull, got.busy, got.done, got.read_value, got.presence));
                end
            end
            m_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Count down a long receiver hold-off once one is requested
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_cnt  <= 0;
            hold_seen <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt  <= LONG_HOLD;
        end
    end

    function automatic void push_tick(logic v, op_t op, logic [7:0] b, logic line);
        tick_t t;
        t.cmd_valid = v;
        t.op        = op;
        t.cmd_byte  = b;
        t.line      = line;
        tick_q.push_back(t);
        ticks_queued++;
    endfunction

    function automatic op_t any_op();
        return op_t'($urandom_range(0, 3));
    endfunction

    // Wait for every status to come back
    task automatic wait_results();
        while (results_checked != ticks_queued)
            @(negedge clk);
    endtask

    // Feed quiet ticks with the line high until the sequencer is idle, then
    // let the pipeline settle
    task automatic drain_to_idle();
        bit settled;
        settled = 1'b0;
        while (!settled) begin
            wait_results();
            if (bus_phase == PH_IDLE)
                settled = 1'b1;
            else
                for (int k = 0; k < 16; k++)
                    push_tick(1'b0, any_op(), 8'($urandom), 1'b1);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_timing(logic [IDX_W-1:0] idx, logic [TW-1:0] value);
        @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_index   <= idx;
        cfg_data    <= value;
        timing[idx]  = value;
        @(posedge clk);
        cfg_we      <= 1'b0;
    endtask

    // Issue one command, hold the line at a level for a while (optionally
    // with extra command requests, ignored while the command runs), then run it out
    task automatic run_command(op_t op, logic [7:0] b, logic level, int hold_ticks,
                               logic junk_valid);
        push_tick(1'b1, op, b, level);
        for (int k = 0; k < hold_ticks; k++)
            push_tick(junk_valid, any_op(), 8'($urandom), level);
        drain_to_idle();
    endtask

    // Mostly whole commands followed by quiet ticks, the rest random noise
    task automatic random_traffic(int n_ticks, bit pause_midway);
        int  made;
        int  k;
        int  bias;
        bit  paused;
        made   = 0;
        paused = 1'b0;
        while (made < n_ticks) begin
            if (pause_midway && !paused && made >= n_ticks / 2) begin
                wait_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                bias = $urandom_range(0, 2);
                k    = $urandom_range(4, 40);
                push_tick(1'b1, any_op(), 8'($urandom), 1'($urandom));
                for (int j = 0; j < k; j++)
                    push_tick(1'b0, any_op(), 8'($urandom),
                              (bias == 2) ? 1'($urandom) : 1'(bias));
                made += k + 1;
            end else begin
                k = $urandom_range(1, 8);
                for (int j = 0; j < k; j++)
                    push_tick(1'($urandom), any_op(), 8'($urandom), 1'($urandom));
                made += k;
            end
        end
    endtask

    task automatic random_timing();
        for (int i = 0; i < NREG; i++)
            write_timing(IDX_W'(i), ($urandom_range(0, 7) == 0) ?
                         TW'($urandom_range(4, 24)) : TW'($urandom_range(0, 3)));
    endtask

    initial begin
        clear_sequencer();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed at reset timing: a poll that ends as its wait runs out and one
        // that ends after a low stretch
        run_command(OP_POLL, 8'h00, 1'b1, 0, 1'b0);
        run_command(OP_POLL, 8'h00, 1'b0, 30, 1'b0);

        // Short timings: presence and no device, byte extremes, commands
        // offered while busy, reads of all-low and all-high lines
        write_timing(R_RST_LOW, TW'(5));
        write_timing(R_PRES_WT, TW'(3));
        write_timing(R_PRES_REC, TW'(4));
        write_timing(R_SHORT, TW'(1));
        write_timing(R_LONG, TW'(3));
        write_timing(R_RD_DLY, TW'(2));
        write_timing(R_RD_REC, TW'(3));
        write_timing(R_POLL, TW'(2));
        run_command(OP_RESET, 8'h00, 1'b0, 20, 1'b0);
        run_command(OP_RESET, 8'h00, 1'b1, 0, 1'b0);
        run_command(OP_WRITE, 8'h00, 1'b1, 0, 1'b0);
        run_command(OP_WRITE, 8'hFF, 1'b1, 0, 1'b0);
        run_command(OP_WRITE, 8'h5A, 1'b1, 40, 1'b1);
        run_command(OP_READ, 8'h00, 1'b0, 60, 1'b0);
        run_command(OP_READ, 8'h00, 1'b1, 0, 1'b0);
        run_command(OP_POLL, 8'h00, 1'b0, 10, 1'b0);

        // All timing registers zero: every timed phase lasts a single tick
        for (int i = 0; i < NREG; i++)
            write_timing(IDX_W'(i), '0);
        run_command(OP_RESET, 8'h00, 1'b0, 3, 1'b0);
        run_command(OP_WRITE, 8'hA5, 1'b1, 0, 1'b0);
        run_command(OP_READ, 8'hFF, 1'b0, 30, 1'b0);
        run_command(OP_POLL, 8'h00, 1'b0, 5, 1'b0);
        run_command(OP_RESET, 8'hFF, 1'b1, 4, 1'b1);

        // Random traffic under each idle pattern with fresh small timings
        random_timing();
        send_idle_pct = 0;
        stall_pct     = 0;
        random_traffic(200, 1'b0);
        drain_to_idle();

        random_timing();
        send_idle_pct = 84;
        stall_pct     = 0;
        random_traffic(200, 1'b1);
        drain_to_idle();

        random_timing();
        send_idle_pct = 0;
        stall_pct     = 84;
        hold_req++;
        random_traffic(200, 1'b0);
        drain_to_idle();

        random_timing();
        send_idle_pct = 22;
        stall_pct     = 22;
        random_traffic(200, 1'b0);
        drain_to_idle();

        wait_results();
        repeat (8) @(posedge clk);
        if (bus_expect_q.size() != 0)
            flag_error($sformatf("%0d statuses never arrived", bus_expect_q.size()));
        if (errors == 0)
            $display("onewire_bus_master_unit regression: pass");
        else
            $display("onewire_bus_master_unit regression: fail");
        $finish;
    end

    // Watchdog well beyond the slowest correct run
    initial begin
        #20ms;
        $display("onewire_bus_master_unit regression: fail");
        $finish;
    end

endmodule
